### src/pstc_pkg.sv
// ----------------------------------------------------------------------------
// pstc_pkg
// shared widths, constants, angle table and word types for the polar scan
// converter
// ----------------------------------------------------------------------------
package pstc_pkg;

    localparam int ROTATION_STEPS_DEFAULT = 16;

    localparam int RANGE_W   = 16;
    localparam int BEARING_W = 16;
    localparam int OUT_W     = 17;
    localparam int MAG_W     = BEARING_W + 1;

    localparam int TURN_W      = 33;
    localparam int TURN_PROD_W = MAG_W + TURN_W;
    localparam int TURN_SHIFT  = 16;
    localparam int GAIN_W      = 32;
    localparam int GAIN_PROD_W = RANGE_W + GAIN_W;
    localparam int GAIN_SHIFT  = 12;
    localparam int START_W     = GAIN_PROD_W - GAIN_SHIFT;
    localparam int PHASE_W     = 32;
    localparam int FOLD_W      = PHASE_W - 1;

    localparam logic [TURN_W-1:0]  TURN_MULT    = 33'd5468522204;
    localparam logic [GAIN_W-1:0]  GAIN_Q32     = 32'd2608131496;
    localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam int                 TURN_ROUND   = 1 << (TURN_SHIFT - 1);

    localparam int VEC_W        = START_W + 2;
    localparam int ANG_W        = PHASE_W + 2;
    localparam int RES_W        = 25;
    localparam int TWO_PI_W     = 28;
    localparam int ZR_PROD_W    = RES_W + TWO_PI_W;
    localparam int ZR_SHIFT     = 32;
    localparam int ZR_W         = ZR_PROD_W - ZR_SHIFT;
    localparam int PROD_W       = VEC_W + ZR_W;
    localparam int CORR_SHIFT   = 24;
    localparam int CORR_W       = VEC_W + 1;
    localparam int OUT_FRAC     = 20;
    localparam int RND_W        = CORR_W - OUT_FRAC;
    localparam int ROUND_BIAS   = 1 << (OUT_FRAC - 1);
    localparam int OUT_LIMIT    = 65535;

    localparam logic signed [TWO_PI_W-1:0] TWO_PI_Q24 = 28'sd105414357;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W       = 31;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int INFLIGHT_W  = 2;
    localparam int OCC_W       = LEVEL_W + 1;

    typedef struct packed {
        logic [START_W-1:0] x_start;
        logic [FOLD_W-1:0]  angle;
        logic               neg_c;
        logic               neg_s;
    } scan_item_t;

    typedef struct packed {
        logic                  push;
        logic [INFLIGHT_W-1:0] inflight;
    } front_status_t;

endpackage

### src/pstc_front.sv
// ----------------------------------------------------------------------------
// pstc_front
// takes a beam word, scales the bearing to turns, folds it into the first
// quadrant and applies the gain to the range
// ----------------------------------------------------------------------------
module pstc_front
    import pstc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [RANGE_W-1:0]          range_fixed,
    input  logic signed [BEARING_W-1:0] bearing_fixed,
    output front_status_t               status,
    output scan_item_t                  item
);

    logic [MAG_W-1:0]       mag;
    logic                   s1_valid_reg;
    logic [TURN_PROD_W-1:0] turn_prod_reg;
    logic [TURN_PROD_W-1:0] turn_prod_next;
    logic [GAIN_PROD_W-1:0] gain_prod_reg;
    logic [GAIN_PROD_W-1:0] gain_prod_next;
    logic                   ang_neg_reg;

    logic                   push_reg;
    scan_item_t             item_reg;
    scan_item_t             item_next;

    logic [TURN_PROD_W-1:0] turn_sum;
    logic [PHASE_W-1:0]     phase;
    logic [PHASE_W-1:0]     phase_half;
    logic [PHASE_W-1:0]     phase_quad;
    logic                   neg_c;
    logic                   neg_s;

    always_comb
    begin
        if (bearing_fixed[BEARING_W-1])
        begin
            mag = MAG_W'(1 << BEARING_W) - {1'b0, bearing_fixed};
        end
        else
        begin
            mag = {1'b0, bearing_fixed};
        end
        turn_prod_next = TURN_PROD_W'(mag) * TURN_PROD_W'(TURN_MULT);
        gain_prod_next = GAIN_PROD_W'(range_fixed) * GAIN_PROD_W'(GAIN_Q32);
    end

    // quadrant fold
    always_comb
    begin
        turn_sum = turn_prod_reg + TURN_PROD_W'(TURN_ROUND);
        phase    = turn_sum[TURN_SHIFT +: PHASE_W];
        neg_c    = 1'b0;
        neg_s    = 1'b0;
        if (phase >= HALF_TURN)
        begin
            phase_half = phase - HALF_TURN;
            neg_c      = 1'b1;
            neg_s      = 1'b1;
        end
        else
        begin
            phase_half = phase;
        end
        if (phase_half > QUARTER_TURN)
        begin
            phase_quad = HALF_TURN - phase_half;
            neg_c      = !neg_c;
        end
        else
        begin
            phase_quad = phase_half;
        end
        item_next.x_start = gain_prod_reg[GAIN_PROD_W-1:GAIN_SHIFT];
        item_next.angle   = phase_quad[FOLD_W-1:0];
        item_next.neg_c   = neg_c;
        item_next.neg_s   = neg_s ^ ang_neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            push_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            push_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        turn_prod_reg <= turn_prod_next;
        gain_prod_reg <= gain_prod_next;
        ang_neg_reg   <= bearing_fixed[BEARING_W-1];
        item_reg      <= item_next;
    end

    assign status.push     = push_reg;
    assign status.inflight = INFLIGHT_W'(s1_valid_reg) + INFLIGHT_W'(push_reg);
    assign item            = item_reg;

endmodule

### src/pstc_queue.sv
// ----------------------------------------------------------------------------
// pstc_queue
// short first-in first-out store between the front and the rotation pipeline
// ----------------------------------------------------------------------------
module pstc_queue
    import pstc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scan_item_t          push_item,
    output logic                head_valid,
    output scan_item_t          head_item,
    output logic [LEVEL_W-1:0]  level
);

    scan_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic                pop;

    // the rotation pipeline never stalls, so the head leaves every cycle whenever the queue holds a word
    assign pop = (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = pop;
    assign head_item  = mem_reg[rd_ptr_reg];
    assign level      = level_reg;

    // no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && level_reg == LEVEL_W'(QUEUE_DEPTH)))
        else $error("queue overflow");

    // a word pushed into an empty queue is offered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && level_reg == '0) |=> head_valid)
        else $error("pushed word not offered");

endmodule

### src/pstc_back.sv
// ----------------------------------------------------------------------------
// pstc_back
// pipelined rotation stages, residual angle correction, rounding and
// saturation of the result word
// ----------------------------------------------------------------------------
module pstc_back
    import pstc_pkg::*;
#(
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEFAULT
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  scan_item_t              item,
    output logic                    strobe,
    output logic signed [OUT_W-1:0] x_coord,
    output logic signed [OUT_W-1:0] y_coord
);

    logic signed [VEC_W-1:0]  x_src  [ROTATION_STEPS];
    logic signed [VEC_W-1:0]  y_src  [ROTATION_STEPS];
    logic signed [ANG_W-1:0]  z_src  [ROTATION_STEPS];
    logic signed [VEC_W-1:0]  x_next [ROTATION_STEPS];
    logic signed [VEC_W-1:0]  y_next [ROTATION_STEPS];
    logic signed [ANG_W-1:0]  z_next [ROTATION_STEPS];
    logic signed [VEC_W-1:0]  x_reg  [ROTATION_STEPS];
    logic signed [VEC_W-1:0]  y_reg  [ROTATION_STEPS];
    logic signed [ANG_W-1:0]  z_reg  [ROTATION_STEPS];
    logic [ROTATION_STEPS-1:0] vld_reg;
    logic [ROTATION_STEPS-1:0] negc_reg;
    logic [ROTATION_STEPS-1:0] negs_reg;

    logic signed [RES_W-1:0]     z_res;
    logic signed [ZR_PROD_W-1:0] zr_prod;
    logic signed [ZR_W-1:0]      zr_reg;
    logic signed [VEC_W-1:0]     xr_reg;
    logic signed [VEC_W-1:0]     yr_reg;
    logic                        r1_valid_reg;
    logic                        r1_negc_reg;
    logic                        r1_negs_reg;

    logic signed [PROD_W-1:0]    prod_x_next;
    logic signed [PROD_W-1:0]    prod_y_next;
    logic signed [PROD_W-1:0]    prod_x_reg;
    logic signed [PROD_W-1:0]    prod_y_reg;
    logic signed [VEC_W-1:0]     xp_reg;
    logic signed [VEC_W-1:0]     yp_reg;
    logic                        r2_valid_reg;
    logic                        r2_negc_reg;
    logic                        r2_negs_reg;

    logic signed [CORR_W-1:0]    xc;
    logic signed [CORR_W-1:0]    yc;
    logic                        strobe_reg;
    logic signed [OUT_W-1:0]     x_coord_reg;
    logic signed [OUT_W-1:0]     y_coord_reg;

    function automatic logic signed [OUT_W-1:0] round_out(
        input logic signed [CORR_W-1:0] v,
        input logic                     neg
    );
        logic signed [CORR_W-1:0] biased;
        logic signed [RND_W-1:0]  r;
        logic signed [OUT_W-1:0]  s;
        biased = v + CORR_W'(ROUND_BIAS);
        r      = biased[CORR_W-1:OUT_FRAC];
        if (r > $signed(RND_W'(OUT_LIMIT)))
        begin
            s = OUT_W'(OUT_LIMIT);
        end
        else if (r < -$signed(RND_W'(OUT_LIMIT)))
        begin
            s = -$signed(OUT_W'(OUT_LIMIT));
        end
        else
        begin
            s = r[OUT_W-1:0];
        end
        return neg ? -s : s;
    endfunction

    // micro-rotations, one per stage
    always_comb
    begin
        x_src[0] = $signed({{(VEC_W-START_W){1'b0}}, item.x_start});
        y_src[0] = '0;
        z_src[0] = $signed({{(ANG_W-FOLD_W){1'b0}}, item.angle});
        for (int i = 1; i < ROTATION_STEPS; i++)
        begin
            x_src[i] = x_reg[i-1];
            y_src[i] = y_reg[i-1];
            z_src[i] = z_reg[i-1];
        end
        for (int i = 0; i < ROTATION_STEPS; i++)
        begin
            if (!z_src[i][ANG_W-1])
            begin
                x_next[i] = x_src[i] - (y_src[i] >>> i);
                y_next[i] = y_src[i] + (x_src[i] >>> i);
                z_next[i] = z_src[i] - $signed({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[i]});
            end
            else
            begin
                x_next[i] = x_src[i] + (y_src[i] >>> i);
                y_next[i] = y_src[i] - (x_src[i] >>> i);
                z_next[i] = z_src[i] + $signed({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[i]});
            end
        end
    end

    // residual angle correction
    always_comb
    begin
        z_res       = z_reg[ROTATION_STEPS-1][RES_W-1:0];
        zr_prod     = ZR_PROD_W'(z_res) * ZR_PROD_W'(TWO_PI_Q24);
        prod_x_next = PROD_W'(xr_reg) * PROD_W'(zr_reg);
        prod_y_next = PROD_W'(yr_reg) * PROD_W'(zr_reg);
        xc = CORR_W'(xp_reg) - CORR_W'($signed(prod_y_reg[PROD_W-1:CORR_SHIFT]));
        yc = CORR_W'(yp_reg) + CORR_W'($signed(prod_x_reg[PROD_W-1:CORR_SHIFT]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            vld_reg      <= {vld_reg[ROTATION_STEPS-2:0], item_valid};
            r1_valid_reg <= vld_reg[ROTATION_STEPS-1];
            r2_valid_reg <= r1_valid_reg;
            strobe_reg   <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROTATION_STEPS; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
        negc_reg <= {negc_reg[ROTATION_STEPS-2:0], item.neg_c};
        negs_reg <= {negs_reg[ROTATION_STEPS-2:0], item.neg_s};

        zr_reg      <= zr_prod[ZR_PROD_W-1:ZR_SHIFT];
        xr_reg      <= x_reg[ROTATION_STEPS-1];
        yr_reg      <= y_reg[ROTATION_STEPS-1];
        r1_negc_reg <= negc_reg[ROTATION_STEPS-1];
        r1_negs_reg <= negs_reg[ROTATION_STEPS-1];

        prod_x_reg  <= prod_x_next;
        prod_y_reg  <= prod_y_next;
        xp_reg      <= xr_reg;
        yp_reg      <= yr_reg;
        r2_negc_reg <= r1_negc_reg;
        r2_negs_reg <= r1_negs_reg;

        x_coord_reg <= round_out(xc, r2_negc_reg);
        y_coord_reg <= round_out(yc, r2_negs_reg);
    end

    assign strobe  = strobe_reg;
    assign x_coord = x_coord_reg;
    assign y_coord = y_coord_reg;

    // saturation keeps results symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (x_coord_reg != {1'b1, {(OUT_W-1){1'b0}}}
                        && y_coord_reg != {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("result beyond saturation limit");

endmodule

### src/polar_scan_to_cartesian.sv
// ----------------------------------------------------------------------------
// polar_scan_to_cartesian: beam range and bearing to x and y coordinates
// an accepted word gives its strobe after the front, queue, rotation and
// correction registers; one word may be taken every cycle, busy stays low in use
// limited by the rotation pipeline, one micro-rotation stage per step
// reset clears all valid flags and queue pointers; no result follows reset
// ----------------------------------------------------------------------------
module polar_scan_to_cartesian
    import pstc_pkg::*;
#(
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEFAULT
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [RANGE_W-1:0]          range_fixed,
    input  logic signed [BEARING_W-1:0] bearing_fixed,
    output logic                        strobe,
    output logic signed [OUT_W-1:0]     x_coord,
    output logic signed [OUT_W-1:0]     y_coord
);

    localparam int LATENCY = ROTATION_STEPS + 6;

    logic                accept;
    front_status_t       front_status;
    scan_item_t          front_item;
    logic                head_valid;
    scan_item_t          head_item;
    logic [LEVEL_W-1:0]  level;
    logic [OCC_W-1:0]    occupancy;

    assign accept    = start && !busy;
    assign occupancy = OCC_W'(level) + OCC_W'(front_status.inflight);
    assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));

    pstc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .range_fixed   (range_fixed),
        .bearing_fixed (bearing_fixed),
        .status        (front_status),
        .item          (front_item)
    );

    pstc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_status.push),
        .push_item  (front_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .level      (level)
    );

    pstc_back #(
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item       (head_item),
        .strobe     (strobe),
        .x_coord    (x_coord),
        .y_coord    (y_coord)
    );

    // every accepted word comes out with its strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY strobe)
        else $error("result word missing");

    // no result without an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(accept, LATENCY))
        else $error("result word without input");

endmodule
